/* hw/rtl/bf16_to_fp8_scaled_cast_amax_unit_assert.svh */
// assertion macros for the scaled cast unit checker
// no dependencies
`ifndef BF16_TO_FP8_SCALED_CAST_AMAX_UNIT_ASSERT_SVH
`define BF16_TO_FP8_SCALED_CAST_AMAX_UNIT_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bf8c_pkg.sv */
// shared types and constants of the scaled bf16 to fp8 cast unit
// no dependencies
`default_nettype none

package bf8c_pkg;

    typedef enum logic [2:0] {
        ST_READY,
        ST_ADD,
        ST_DLOAD,
        ST_DRUN,
        ST_DSTORE,
        ST_MUL,
        ST_CODE
    } state_t;

    typedef enum logic [1:0] {
        DIV_RCP,
        DIV_SCL,
        DIV_INV
    } div_op_t;

    typedef struct packed {
        logic    add_en;
        logic    div_load;
        logic    div_step;
        logic    div_store;
        div_op_t div_op;
        logic    in_load;
        logic    mul_en;
        logic    code_en;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    localparam logic [31:0] EPS_BITS  = 32'h322C_0000;
    localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
    localparam logic [31:0] F32_INF   = 32'h7F80_0000;
    localparam logic [15:0] BF16_QNAN = 16'h7FC0;
    localparam logic [6:0]  E4M3_MAX  = 7'h7E;
    localparam logic [4:0]  DIV_STEPS = 5'd27;
    localparam logic [7:0]  SIG_ONE   = 8'h80;
    localparam logic [7:0]  SIG_448   = 8'hE0;

endpackage

`default_nettype wire

/* hw/rtl/bf16_to_fp8_scaled_cast_amax_unit.sv */
// Scaled bf16 to fp8 E4M3 cast with running absolute maximum. Each input word carries
// four bf16 values and gives one output word with four E4M3 codes, the running amax and
// the float32 inverse scale. After reset and after every previous_amax write the unit
// runs a setup with s_tready low: the ready state sees the write, one add, then
// three divisions on one shared radix-2 divider (load, 27 steps, finish and store
// each). After that an item goes through accept, product stage and encode stage into
// the output register; a new word is taken while an earlier result still waits in
// the output register.
// depends on bf8c_pkg, bf8c_ctrl, bf8c_dp
`default_nettype none

module bf16_to_fp8_scaled_cast_amax_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value_a, value_b, value_c, value_d
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // code_a, code_b, code_c, code_d, running_max_out,
                                   // inverse_scale, zero pad
);

    bf8c_pkg::cmd_t  cmd;
    bf8c_pkg::stat_t stat;

    bf8c_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bf8c_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd        (cmd),
        .stat       (stat),
        .s_tdata    (s_tdata),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/bf8c_ctrl.sv */
// controller of the scaled cast unit: setup sequence, item steps, output word valid
// depends on bf8c_pkg
`default_nettype none

module bf8c_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  bf8c_pkg::stat_t stat,
    output bf8c_pkg::cmd_t  cmd
);

    bf8c_pkg::state_t  state_reg, state_next;
    bf8c_pkg::div_op_t op_reg, op_next;
    logic              dirty_reg, dirty_next;
    logic              valid_reg, valid_next;
    logic              out_free;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bf8c_pkg::ST_READY;
            op_reg    <= bf8c_pkg::DIV_RCP;
            dirty_reg <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            dirty_reg <= dirty_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            bf8c_pkg::ST_READY: begin
                if (dirty_reg) begin
                    state_next = bf8c_pkg::ST_ADD;
                    op_next    = bf8c_pkg::DIV_RCP;
                end else if (s_tvalid) begin
                    state_next = bf8c_pkg::ST_MUL;
                end
            end
            bf8c_pkg::ST_ADD:   state_next = bf8c_pkg::ST_DLOAD;
            bf8c_pkg::ST_DLOAD: state_next = bf8c_pkg::ST_DRUN;
            bf8c_pkg::ST_DRUN: begin
                if (stat.div_done) state_next = bf8c_pkg::ST_DSTORE;
            end
            bf8c_pkg::ST_DSTORE: begin
                case (op_reg)
                    bf8c_pkg::DIV_RCP: begin
                        op_next    = bf8c_pkg::DIV_SCL;
                        state_next = bf8c_pkg::ST_DLOAD;
                    end
                    bf8c_pkg::DIV_SCL: begin
                        op_next    = bf8c_pkg::DIV_INV;
                        state_next = bf8c_pkg::ST_DLOAD;
                    end
                    default: state_next = bf8c_pkg::ST_READY;
                endcase
            end
            bf8c_pkg::ST_MUL:   state_next = bf8c_pkg::ST_CODE;
            bf8c_pkg::ST_CODE: begin
                if (out_free) state_next = bf8c_pkg::ST_READY;
            end
            default: state_next = bf8c_pkg::ST_READY;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.div_op    = op_reg;
        s_tready      = (state_reg == bf8c_pkg::ST_READY) && !dirty_reg;
        cmd.in_load   = s_tready && s_tvalid;
        cmd.add_en    = (state_reg == bf8c_pkg::ST_ADD);
        cmd.div_load  = (state_reg == bf8c_pkg::ST_DLOAD);
        cmd.div_step  = (state_reg == bf8c_pkg::ST_DRUN) && !stat.div_done;
        cmd.div_store = (state_reg == bf8c_pkg::ST_DSTORE);
        cmd.mul_en    = (state_reg == bf8c_pkg::ST_MUL);
        cmd.code_en   = (state_reg == bf8c_pkg::ST_CODE) && out_free;
    end

    always_comb begin
        if (cfg_wr_en) begin
            dirty_next = 1'b1;
        end else if (state_reg == bf8c_pkg::ST_READY) begin
            dirty_next = 1'b0;
        end else begin
            dirty_next = dirty_reg;
        end
        if (cmd.code_en) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/bf8c_dp.sv */
// datapath of the scaled cast unit: scale setup, shared divider, lane arithmetic, amax
// depends on bf8c_pkg
`default_nettype none

module bf8c_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [30:0]     cfg_wr_data,
    input  bf8c_pkg::cmd_t  cmd,
    output bf8c_pkg::stat_t stat,
    input  logic [63:0]     s_tdata,
    output logic [95:0]     m_tdata
);

    function automatic logic [15:0] bf16_rnd(input logic [31:0] b);
        logic [31:0] t;
        t = b + 32'h0000_7FFF + {31'd0, b[16]};
        if (b[30:0] > bf8c_pkg::F32_INF[30:0]) begin
            bf16_rnd = bf8c_pkg::BF16_QNAN;
        end else begin
            bf16_rnd = t[31:16];
        end
    endfunction

    function automatic logic [31:0] add_eps(input logic [30:0] a);
        logic [7:0]  eb, es, dexp, ex;
        logic [23:0] mb, ms;
        logic [26:0] sx, sal, lmask;
        logic [4:0]  sh;
        logic [27:0] sum;
        logic [26:0] m;
        logic        up;
        logic [31:0] r;
        if (a >= bf8c_pkg::EPS_BITS[30:0]) begin
            eb = a[30:23];
            mb = {1'b1, a[22:0]};
            es = bf8c_pkg::EPS_BITS[30:23];
            ms = {1'b1, bf8c_pkg::EPS_BITS[22:0]};
        end else begin
            eb = bf8c_pkg::EPS_BITS[30:23];
            mb = {1'b1, bf8c_pkg::EPS_BITS[22:0]};
            es = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
            ms = {a[30:23] != 8'd0, a[22:0]};
        end
        dexp  = eb - es;
        sh    = (dexp > 8'd26) ? 5'd27 : dexp[4:0];
        sx    = {ms, 3'b000};
        lmask = ~(27'h7FF_FFFF << sh);
        sal   = (sx >> sh) | {26'd0, |(sx & lmask)};
        sum   = {1'b0, mb, 3'b000} + {1'b0, sal};
        if (sum[27]) begin
            m  = {sum[27:2], sum[1] | sum[0]};
            ex = eb + 8'd1;
        end else begin
            m  = sum[26:0];
            ex = eb;
        end
        up = m[2] & (m[1] | m[0] | m[3]);
        r  = {1'b0, ex, m[25:3]} + {31'd0, up};
        if (a[30:23] == 8'hFF) begin
            r = {1'b0, a};
        end
        add_eps = r;
    endfunction

    function automatic logic [31:0] div_rnd(input logic [26:0] q, input logic st,
                                            input logic signed [9:0] e);
        logic [23:0]       sig;
        logic              g, r, up;
        logic signed [9:0] ee, shs, eb;
        logic [1:0]        sh;
        logic [24:0]       w, w2, wm;
        logic [7:0]        ef;
        if (q[26]) begin
            sig = q[26:3];
            g   = q[2];
            r   = q[1] | q[0] | st;
            ee  = e;
        end else begin
            sig = q[25:2];
            g   = q[1];
            r   = q[0] | st;
            ee  = e - 10'sd1;
        end
        eb = ee + 10'sd127;
        if (ee < -10'sd126) begin
            shs = -10'sd126 - ee;
            sh  = (shs > 10'sd3) ? 2'd3 : shs[1:0];
            w   = {sig, g};
            wm  = ~(25'h1FF_FFFF << sh);
            r   = r | (|(w & wm));
            w2  = w >> sh;
            sig = w2[24:1];
            g   = w2[0];
            ef  = 8'd0;
        end else begin
            ef = eb[7:0];
        end
        up      = g & (r | sig[0]);
        div_rnd = {1'b0, ef, sig[22:0]} + {31'd0, up};
    endfunction

    logic [30:0]       amax_reg;
    logic [30:0]       rm_reg, rm_next;
    logic [15:0]       den_reg, scl_reg;
    logic [31:0]       inv_reg;
    logic [7:0]        rs_reg;
    logic signed [9:0] re_reg;
    logic              rz_reg, rn_reg;
    logic              den_nan, den_inf;

    logic [9:0]        rem_reg;
    logic [26:0]       quot_reg;
    logic [4:0]        cnt_reg;
    logic [7:0]        dnum_reg, dden_reg;
    logic signed [9:0] dexp_reg;

    logic [63:0]       in_reg;
    logic [95:0]       out_reg;

    logic              fix_reg [4];
    logic [7:0]        fcode_reg [4];
    logic [7:0]        ts_reg [4];
    logic signed [9:0] et_reg [4];
    logic              sg_reg [4];

    assign den_nan = (den_reg[14:7] == 8'hFF) && (den_reg[6:0] != 7'd0);
    assign den_inf = (den_reg[14:0] == 15'h7F80);

    // config, running amax and divider step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amax_reg <= '0;
            rm_reg   <= '0;
            cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) amax_reg <= cfg_wr_data;
            if (cmd.in_load) rm_reg <= rm_next;
            if (cmd.div_load) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_comb begin
        logic [30:0] ab;
        rm_next = rm_reg;
        for (int i = 0; i < 4; i++) begin
            ab = {s_tdata[16*i +: 15], 16'h0000};
            if (ab <= bf8c_pkg::F32_INF[30:0] && ab > rm_next) rm_next = ab;
        end
    end

    assign stat.div_done = (cnt_reg == bf8c_pkg::DIV_STEPS);

    // divider operands
    logic [7:0]        ld_num, ld_den;
    logic signed [9:0] ld_en, ld_ed;

    always_comb begin
        case (cmd.div_op)
            bf8c_pkg::DIV_RCP: begin
                ld_num = bf8c_pkg::SIG_ONE;
                ld_en  = 10'sd0;
                ld_den = {1'b1, den_reg[6:0]};
                ld_ed  = $signed({2'b00, den_reg[14:7]}) - 10'sd127;
            end
            bf8c_pkg::DIV_SCL: begin
                ld_num = bf8c_pkg::SIG_448;
                ld_en  = 10'sd8;
                ld_den = {1'b1, den_reg[6:0]};
                ld_ed  = $signed({2'b00, den_reg[14:7]}) - 10'sd127;
            end
            default: begin
                ld_num = bf8c_pkg::SIG_ONE;
                ld_en  = 10'sd0;
                ld_den = {1'b1, scl_reg[6:0]};
                ld_ed  = $signed({2'b00, scl_reg[14:7]}) - 10'sd127;
            end
        endcase
    end

    logic [31:0]       div_f32;
    logic [15:0]       rcp16;
    logic [7:0]        rcp_sig;
    logic signed [9:0] rcp_exp;
    logic [9:0]        rem_diff;
    logic              rem_ge;

    assign rem_ge   = rem_reg >= {2'b00, dden_reg};
    assign rem_diff = rem_reg - {2'b00, dden_reg};
    assign div_f32  = div_rnd(quot_reg, rem_reg != 10'd0, dexp_reg);
    assign rcp16    = bf16_rnd(div_f32);

    always_comb begin
        logic [2:0] pos;
        pos = 3'd0;
        for (int p = 0; p < 7; p++) begin
            if (rcp16[p]) pos = 3'(p);
        end
        if (rcp16[14:7] != 8'd0) begin
            rcp_sig = {1'b1, rcp16[6:0]};
            rcp_exp = $signed({2'b00, rcp16[14:7]}) - 10'sd127;
        end else begin
            rcp_sig = {1'b0, rcp16[6:0]} << (3'd7 - pos);
            rcp_exp = $signed({7'd0, pos}) - 10'sd133;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_en) den_reg <= bf16_rnd(add_eps(amax_reg));
        if (cmd.div_load) begin
            rem_reg  <= {2'b00, ld_num};
            dden_reg <= ld_den;
            dnum_reg <= ld_num;
            dexp_reg <= ld_en - ld_ed;
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_ge ? {rem_diff[8:0], 1'b0} : {rem_reg[8:0], 1'b0};
            quot_reg <= {quot_reg[25:0], rem_ge};
        end
        if (cmd.div_store) begin
            case (cmd.div_op)
                bf8c_pkg::DIV_RCP: begin
                    rs_reg <= rcp_sig;
                    re_reg <= rcp_exp;
                    rz_reg <= den_inf || (rcp16[14:0] == 15'd0) || (dnum_reg == 8'd0);
                    rn_reg <= den_nan;
                end
                bf8c_pkg::DIV_SCL: scl_reg <= rcp16;
                default: begin
                    if (den_nan) begin
                        inv_reg <= bf8c_pkg::F32_QNAN;
                    end else if (den_inf) begin
                        inv_reg <= bf8c_pkg::F32_INF;
                    end else begin
                        inv_reg <= div_f32;
                    end
                end
            endcase
        end
    end

    // lane stage one: product, first bf16 rounding and special-case codes
    logic              s1_fix [4];
    logic [7:0]        s1_fcode [4];
    logic [7:0]        s1_ts [4];
    logic signed [9:0] s1_et [4];

    always_comb begin
        logic [15:0]       x, p;
        logic signed [9:0] xe, ee;
        logic [7:0]        sg8;
        logic              g, r, up;
        logic [8:0]        s9;
        for (int i = 0; i < 4; i++) begin
            x   = in_reg[16*i +: 16];
            xe  = $signed({2'b00, x[14:7]}) - 10'sd127;
            p   = rs_reg * {1'b1, x[6:0]};
            if (p[15]) begin
                sg8 = p[15:8];
                g   = p[7];
                r   = |p[6:0];
                ee  = re_reg + xe + 10'sd1;
            end else begin
                sg8 = p[14:7];
                g   = p[6];
                r   = |p[5:0];
                ee  = re_reg + xe;
            end
            up = g & (r | sg8[0]);
            s9 = {1'b0, sg8} + {8'd0, up};
            if (s9[8]) begin
                s1_ts[i] = 8'h80;
                s1_et[i] = ee + 10'sd1;
            end else begin
                s1_ts[i] = s9[7:0];
                s1_et[i] = ee;
            end
            s1_fix[i] = 1'b1;
            if (rn_reg || (x[14:7] == 8'hFF && x[6:0] != 7'd0)) begin
                s1_fcode[i] = {1'b0, bf8c_pkg::E4M3_MAX};
            end else if (x[14:7] == 8'hFF) begin
                s1_fcode[i] = rz_reg ? {1'b0, bf8c_pkg::E4M3_MAX}
                                     : {x[15], bf8c_pkg::E4M3_MAX};
            end else if (x[14:7] == 8'd0 || rz_reg || s1_et[i] < -10'sd30) begin
                s1_fcode[i] = {x[15], 7'd0};
            end else if (s1_et[i] > 10'sd8) begin
                s1_fcode[i] = {x[15], bf8c_pkg::E4M3_MAX};
            end else begin
                s1_fcode[i] = 8'd0;
                s1_fix[i]   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) in_reg <= s_tdata;
        if (cmd.mul_en) begin
            for (int i = 0; i < 4; i++) begin
                fix_reg[i]   <= s1_fix[i];
                fcode_reg[i] <= s1_fcode[i];
                ts_reg[i]    <= s1_ts[i];
                et_reg[i]    <= s1_et[i];
                sg_reg[i]    <= in_reg[16*i + 15];
            end
        end
    end

    // lane stage two: times 448, second bf16 rounding, clamp, e4m3 encode
    logic [31:0] codes;

    always_comb begin
        logic [10:0]       u;
        logic [7:0]        sg8, qs, qv, rmask, c8;
        logic              g, r, up;
        logic [8:0]        s9;
        logic signed [9:0] eq, shs, ef;
        logic [3:0]        sh;
        logic [2:0]        hb;
        logic [6:0]        code7;
        for (int i = 0; i < 4; i++) begin
            u = {ts_reg[i], 3'b000} - {3'b000, ts_reg[i]};
            if (u[10]) begin
                sg8 = u[10:3];
                g   = u[2];
                r   = |u[1:0];
                eq  = et_reg[i] + 10'sd9;
            end else begin
                sg8 = u[9:2];
                g   = u[1];
                r   = u[0];
                eq  = et_reg[i] + 10'sd8;
            end
            up = g & (r | sg8[0]);
            s9 = {1'b0, sg8} + {8'd0, up};
            if (s9[8]) begin
                qs = 8'h80;
                eq = eq + 10'sd1;
            end else begin
                qs = s9[7:0];
            end
            if (eq > 10'sd8 || (eq == 10'sd8 && qs > bf8c_pkg::SIG_448)) begin
                qs = bf8c_pkg::SIG_448;
                eq = 10'sd8;
            end
            ef    = eq + 10'sd7;
            shs   = -10'sd2 - eq;
            sh    = shs[3:0];
            hb    = 3'(sh - 4'd1);
            qv    = qs >> sh;
            rmask = ~(8'hFF << hb);
            c8    = '0;
            if (eq >= -10'sd6) begin
                up    = qs[3] & ((|qs[2:0]) | qs[4]);
                c8    = {1'b0, ef[3:0], qs[6:4]} + {7'd0, up};
                code7 = (c8 > {1'b0, bf8c_pkg::E4M3_MAX}) ? bf8c_pkg::E4M3_MAX : c8[6:0];
            end else if (shs > 10'sd8) begin
                code7 = 7'd0;
            end else begin
                up    = qs[hb] & ((|(qs & rmask)) | qv[0]);
                code7 = {4'd0, qv[2:0]} + {6'd0, up};
            end
            codes[8*i +: 8] = fix_reg[i] ? fcode_reg[i] : {sg_reg[i], code7};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.code_en) out_reg <= {1'b0, inv_reg, rm_reg, codes};
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/bf8c_chk.sv */
// port checker of the scaled cast unit, bound to the top level
// depends on bf16_to_fp8_scaled_cast_amax_unit_assert.svh
`default_nettype none
`include "bf16_to_fp8_scaled_cast_amax_unit_assert.svh"

module bf8c_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "output word dropped")
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "stalled word changed")
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second word taken during work")
    `ASSERT_NEXT(a_cfg_setup, aclk, aresetn, cfg_wr_en, !s_tready, "word taken before scale setup")

endmodule

bind bf16_to_fp8_scaled_cast_amax_unit bf8c_chk u_bf8c_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .cfg_wr_en(cfg_wr_en),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

/* test/testbench.sv */
// self-checking bench for the scaled bf16 to fp8 e4m3 cast unit with running amax
// streams random and corner bf16 words under several previous_amax settings
// depends on bf8c_pkg and bf16_to_fp8_scaled_cast_amax_unit
`default_nettype none

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam logic [31:0] F32_448 = 32'h43E0_0000;
    localparam logic [31:0] F32_M448 = 32'hC3E0_0000;

    typedef struct packed {
        logic [31:0] scale_inv;
        logic [30:0] amax;
        logic [7:0]  code_d;
        logic [7:0]  code_c;
        logic [7:0]  code_b;
        logic [7:0]  code_a;
    } cast_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [30:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // value_a, value_b, value_c, value_d
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // code_a, code_b, code_c, code_d, running_max_out,
                                 // inverse_scale, zero pad

    logic [63:0]  pending_words[$];
    cast_word_t   expected_words[$];
    logic [30:0]  amax_reg = '0;
    logic [31:0]  amax_track = '0;
    int           gap_left = 0;
    int           stall_left = 0;
    int           hold_left = 0;
    logic         hold_kick = 1'b0;
    bit           idle_on = 1'b1;
    int           mismatches = 0;
    int           words_in = 0;
    int           words_out = 0;
    int           quiet_cycles = 0;
    int           settings_run = 0;

    bf16_to_fp8_scaled_cast_amax_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [31:0] to_f32(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] s;
        int e;
        int sh;
        d = $realtobits(r);
        s = {d[63], 31'b0};
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? bf8c_pkg::F32_QNAN : (s | bf8c_pkg::F32_INF);
        if (d[62:52] == 0) return s;
        e = int'(d[62:52]) - 1023 + 127;
        sig = {12'b0, 1'b1, d[51:0]};
        sh = (e >= 1) ? 29 : 30 - e;
        if (sh > 62) return s;
        q = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        if (e >= 1) q = q + (64'(e - 1) << 23);
        if (q >= 64'h7F80_0000) return s | bf8c_pkg::F32_INF;
        return s | q[31:0];
    endfunction

    function automatic real to_real(logic [31:0] b);
        real r;
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, (b[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0});
        if (b[30:23] == 0) begin
            r = real'(b[22:0]) * 2.0 ** (-149);
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'b0});
    endfunction

    function automatic logic [31:0] to_bf16(logic [31:0] b);
        if ((b & 32'h7FFF_FFFF) > bf8c_pkg::F32_INF) return bf8c_pkg::F32_QNAN;
        b = b + 32'h7FFF + ((b >> 16) & 32'd1);
        return b & 32'hFFFF_0000;
    endfunction

    function automatic logic [7:0] to_e4m3(logic [31:0] b);
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int e;
        int sh;
        int base;
        int code;
        code = 0;
        if (b[30:23] != 0 && b[30:23] != 8'hFF) begin
            e = int'(b[30:23]) - 127;
            sig = {40'b0, 1'b1, b[22:0]};
            sh = (e >= -6) ? 20 : 14 - e;
            base = (e >= -6) ? (e + 6) * 8 : 0;
            if (sh <= 31) begin
                q = sig >> sh;
                rem = sig & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 1;
                code = base + int'(q);
            end
            if (code > int'(bf8c_pkg::E4M3_MAX)) code = int'(bf8c_pkg::E4M3_MAX);
        end
        return {b[31], 7'(code)};
    endfunction

    // scaled cast of one word, advances the running amax
    function automatic cast_word_t cast_and_track(logic [63:0] w);
        cast_word_t r;
        logic [31:0] eps;
        logic [31:0] denom;
        logic [31:0] rcp;
        logic [31:0] scl;
        logic [31:0] xb;
        logic [31:0] p;
        logic [31:0] q;
        logic [7:0]  codes[4];
        eps = to_bf16(to_f32(1e-8));
        denom = to_bf16(to_f32(to_real({1'b0, amax_reg}) + to_real(eps)));
        if ((denom & 32'h7FFF_FFFF) > bf8c_pkg::F32_INF) begin
            rcp = bf8c_pkg::F32_QNAN;
            r.scale_inv = bf8c_pkg::F32_QNAN;
        end else begin
            rcp = to_bf16(to_f32(1.0 / to_real(denom)));
            scl = to_bf16(to_f32(448.0 / to_real(denom)));
            r.scale_inv = (scl[30:0] == 0) ? bf8c_pkg::F32_INF : to_f32(1.0 / to_real(scl));
        end
        for (int i = 0; i < 4; i++) begin
            xb = {w[16*i +: 16], 16'b0};
            if ((xb & 32'h7FFF_FFFF) <= bf8c_pkg::F32_INF &&
                (xb & 32'h7FFF_FFFF) > amax_track)
                amax_track = xb & 32'h7FFF_FFFF;
            p = to_bf16(to_f32(to_real(rcp) * to_real(xb)));
            q = to_bf16(to_f32(to_real(p) * 448.0));
            if ((q & 32'h7FFF_FFFF) > bf8c_pkg::F32_INF) q = F32_448;
            else if (to_real(q) > 448.0) q = F32_448;
            else if (to_real(q) < -448.0) q = F32_M448;
            codes[i] = to_e4m3(q);
        end
        r.code_a = codes[0];
        r.code_b = codes[1];
        r.code_c = codes[2];
        r.code_d = codes[3];
        r.amax = amax_track[30:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_bf16();
        logic [7:0] ex;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 8))
                0: return 16'h0000;
                1: return 16'h8000;
                2: return 16'h7F80;
                3: return 16'hFF80;
                4: return 16'h7FC0;
                5: return 16'hFFFF;
                6: return 16'h0001;
                7: return 16'h7F7F;
                default: return 16'h8001;
            endcase
        end
        if (sel <= 3) return 16'($urandom);
        ex = amax_reg[30:23];
        if (ex == 0) ex = 8'd1;
        if (ex == 8'hFF) ex = 8'hFE;
        ex = 8'(int'(ex) + $urandom_range(0, 13) - 12);
        return {1'($urandom), ex, 7'($urandom)};
    endfunction

    function automatic logic [63:0] pick_word();
        return {pick_bf16(), pick_bf16(), pick_bf16(), pick_bf16()};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_words.push_back(cast_and_track(s_tdata));
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_tdata <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left <= idle_on ? $urandom_range(0, 9) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_kick) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        cast_word_t got;
        cast_word_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = cast_word_t'(m_tdata[94:0]);
                words_out++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected output word %h", m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want || m_tdata[95] !== 1'b0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("word %0d mismatch: codes exp %h %h %h %h got %h %h %h %h",
                                words_out, want.code_a, want.code_b, want.code_c, want.code_d,
                                got.code_a, got.code_b, got.code_c, got.code_d);
                            $display("    amax exp %h got %h, inv exp %h got %h, pad %b",
                                want.amax, got.amax, want.scale_inv, got.scale_inv,
                                m_tdata[95]);
                        end
                    end
                end
                stall_left <= idle_on ? $urandom_range(0, 9) : 0;
                m_tready <= 1'b0;
            end else if (hold_left > 0 || hold_kick) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_words.size() == 0 && expected_words.size() == 0 && !s_tvalid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("** bf16_to_fp8_scaled_cast_amax_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_amax(logic [30:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        amax_reg = v;
        settings_run++;
    endtask

    initial begin
        logic [30:0] amax_list[10];
        amax_list = '{31'h3F80_0000, 31'h7F80_0000, 31'h7FFF_FFFF, 31'h7F7F_FFFF,
                      31'h0000_0001, 31'h43E0_0000, 31'h0, 31'h7F80_0001, 31'h0, 31'h0};
        amax_list[8] = 31'($urandom);
        amax_list[9] = {1'b0, 4'($urandom_range(6, 9)), 26'($urandom)};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners at the reset setting
        pending_words.push_back({16'h8000, 16'h0000, 16'h7FC0, 16'h7F80});
        pending_words.push_back({16'hFF80, 16'hFFFF, 16'h0001, 16'h8001});
        pending_words.push_back({16'h7F7F, 16'hFF7F, 16'h0080, 16'h8080});
        pending_words.push_back({16'h322C, 16'hB22C, 16'h3200, 16'h2F00});
        pending_words.push_back({16'h2C00, 16'h2D00, 16'h2E00, 16'h3300});
        pending_words.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_words.push_back(64'h0);
        write_amax(31'h3F80_0000);
        pending_words.push_back({16'h3F80, 16'hBF80, 16'h3B00, 16'h3A90});
        pending_words.push_back({16'h3A80, 16'h3A88, 16'h3A98, 16'h3BF0});
        pending_words.push_back({16'h3980, 16'h3900, 16'h3880, 16'h3800});
        pending_words.push_back({16'h3780, 16'h3700, 16'hB6C0, 16'h3640});
        pending_words.push_back({16'h8000, 16'h3F7F, 16'h4000, 16'hC2C0});
        write_amax(31'h7F80_0000);
        pending_words.push_back({16'h3F80, 16'h7F80, 16'hFF80, 16'h7FC0});
        write_amax(31'h7FFF_FFFF);
        pending_words.push_back({16'h3F80, 16'h0000, 16'h8000, 16'hFF80});

        for (int ph = 0; ph < 10; ph++) begin
            write_amax(amax_list[ph]);
            idle_on = (ph % 3 != 2);
            if (ph == 4) begin
                hold_kick <= 1'b1;
                @(posedge aclk);
                hold_kick <= 1'b0;
            end
            for (int i = 0; i < 140; i++) pending_words.push_back(pick_word());
        end
        drain();

        $display("%0d words cast across %0d previous_amax settings, %0d results checked",
            words_in, settings_run, words_out);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("** bf16_to_fp8_scaled_cast_amax_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                expected_words.size());
            $display("** bf16_to_fp8_scaled_cast_amax_unit: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/bf8c_pkg.sv
hw/rtl/bf8c_ctrl.sv
hw/rtl/bf8c_dp.sv
hw/rtl/bf16_to_fp8_scaled_cast_amax_unit.sv
hw/rtl/bf8c_chk.sv
test/testbench.sv
